### hw/rtl/salru_pkg.sv
// Package for the size-aware LRU cache: table geometry, status codes, action codes and the entry type.
// No dependencies.
`default_nettype none
package salru_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ID_W = 64;
    localparam int SZ_W = 32;
    localparam int CAP_W = 40;
    localparam int USED_W = 41;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // one stored entry as held in the table memory
    typedef struct packed {
        logic [ID_W-1:0]  tag;
        logic [SZ_W-1:0]  bytes;
        logic [IDX_W-1:0] rank;
    } entry_t;
    localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

### hw/rtl/salru_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hw/rtl/size_aware_lru_cache.sv
// Top level of the size-aware LRU cache: sequencer, shared sweep over the entry table.
// Depends on salru_pkg and salru_ram.
//
// One command takes a number of sweeps over the 64-entry table. Each sweep reads the entries
// one at a time through the single table RAM port, with a read phase and a data phase each.
// A lookup sweep finds the id, the free slot and the LRU entry. An update sweep re-ranks.
// Each eviction over capacity costs one more lookup and update pair; the eviction on a miss
// into a full table costs one more update sweep before the insert.
// An eviction is put out once the next one is known. The last eviction rides on the final
// result, which is strobed in the last busy cycle. Results cannot be stalled by the receiver.
`default_nettype none
module size_aware_lru_cache (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [63:0] object_id,
    input  wire logic [31:0] object_bytes,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [39:0] cfg_data,
    output logic             result_valid,
    output logic             hit,
    output logic             evicted_valid,
    output logic [63:0]      evicted_id,
    output logic [1:0]       status,
    output logic [39:0]      bytes_used,
    output logic             last_result
);
    localparam int IW = salru_pkg::IDX_W;
    localparam int CW = salru_pkg::CNT_W;
    localparam int USED_W = salru_pkg::USED_W;
    localparam int CAP_W = salru_pkg::CAP_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;  // read entries, gather lookup facts
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_RANK   = 4'd3;  // read-modify-write ranks
    localparam logic [3:0] S_NEXT   = 4'd4;  // after a table change: evict more?
    localparam logic [3:0] S_EVSCAN = 4'd5;  // find LRU for eviction
    localparam logic [3:0] S_FINAL  = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;

    // rank pass operations
    localparam logic [1:0] OP_DROP = 2'd0;  // ranks above r drop by one
    localparam logic [1:0] OP_MRU  = 2'd1;  // ranks below r rise, target set 0
    localparam logic [1:0] OP_INS  = 2'd2;  // all rise, target written new

    logic [3:0] state_reg, state_next;
    logic [salru_pkg::CAP_W-1:0] cap_reg;
    logic [salru_pkg::USED_W-1:0] used_reg, used_next;
    logic [salru_pkg::ENTRIES-1:0] valid_reg, valid_next;

    logic act_reg;
    logic [63:0] id_reg;
    logic [31:0] sz_reg;

    // sweep control: ptr counts 0..ENTRIES-1, phase 0 = issue read, 1 = data back
    logic [CW-1:0] ptr_reg, ptr_next;
    logic phase_reg, phase_next;

    // lookup results
    logic found_reg, found_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [31:0] fbytes_reg, fbytes_next;
    logic [IW-1:0] frank_reg, frank_next;
    logic free_ok_reg, free_ok_next;
    logic [IW-1:0] free_reg, free_next;
    logic lru_ok_reg, lru_ok_next;
    logic [IW-1:0] lru_reg, lru_next;
    logic [IW-1:0] lrank_reg, lrank_next;
    logic [63:0] ltag_reg, ltag_next;
    logic [31:0] lbytes_reg, lbytes_next;

    // pending rank pass
    logic [1:0] op_reg, op_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    logic [IW-1:0] trank_reg, trank_next;
    logic insert_after_reg, insert_after_next;

    // result held for emission
    logic hit_reg, hit_next;
    logic [1:0] st_reg, st_next;
    logic pend_reg, pend_next;          // one eviction awaiting output
    logic [63:0] pend_id_reg, pend_id_next;

    // output registers
    logic rv_reg, rv_next;
    logic o_hit_reg, o_hit_next;
    logic o_ev_reg, o_ev_next;
    logic [63:0] o_id_reg, o_id_next;
    logic [1:0] o_st_reg, o_st_next;
    logic [39:0] o_used_reg, o_used_next;
    logic o_last_reg, o_last_next;

    // table RAM
    logic ram_we;
    logic [IW-1:0] ram_addr;
    salru_pkg::entry_t ram_wdata, ram_rdata;
    logic [IW-1:0] rd_idx;

    salru_ram #(
        .WIDTH(salru_pkg::ENTRY_W),
        .DEPTH(salru_pkg::ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_idx = ptr_reg[IW-1:0];
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign result_valid  = rv_reg;
    assign hit           = o_hit_reg;
    assign evicted_valid = o_ev_reg;
    assign evicted_id    = o_id_reg;
    assign status        = o_st_reg;
    assign bytes_used    = o_used_reg;
    assign last_result   = o_last_reg;

    // sequencer
    always_comb
    begin
        logic vv;
        logic [CW-1:0] ptr_inc;
        salru_pkg::entry_t e;
        state_next = state_reg;
        used_next = used_reg;
        valid_next = valid_reg;
        ptr_next = ptr_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        fidx_next = fidx_reg;
        fbytes_next = fbytes_reg;
        frank_next = frank_reg;
        free_ok_next = free_ok_reg;
        free_next = free_reg;
        lru_ok_next = lru_ok_reg;
        lru_next = lru_reg;
        lrank_next = lrank_reg;
        ltag_next = ltag_reg;
        lbytes_next = lbytes_reg;
        op_next = op_reg;
        tgt_next = tgt_reg;
        trank_next = trank_reg;
        insert_after_next = insert_after_reg;
        hit_next = hit_reg;
        st_next = st_reg;
        pend_next = pend_reg;
        pend_id_next = pend_id_reg;
        rv_next = 1'b0;
        o_hit_next = 1'b0;
        o_ev_next = 1'b0;
        o_id_next = '0;
        o_st_next = salru_pkg::ST_OK;
        o_used_next = '0;
        o_last_next = 1'b0;
        ram_we = 1'b0;
        ram_addr = rd_idx;
        ram_wdata = ram_rdata;
        vv = valid_reg[rd_idx];
        ptr_inc = ptr_reg + CW'(1);
        e = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    ptr_next = '0;
                    phase_next = 1'b0;
                    found_next = 1'b0;
                    free_ok_next = 1'b0;
                    lru_ok_next = 1'b0;
                    pend_next = 1'b0;
                    st_next = salru_pkg::ST_OK;
                end
            end
            S_SCAN, S_EVSCAN:
            begin
                if (phase_reg == 1'b0)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    if (vv)
                    begin
                        if (state_reg == S_SCAN && !found_reg && e.tag == id_reg)
                        begin
                            found_next = 1'b1;
                            fidx_next = rd_idx;
                            fbytes_next = e.bytes;
                            frank_next = e.rank;
                        end
                        if (!lru_ok_reg || e.rank > lrank_reg)
                        begin
                            lru_ok_next = 1'b1;
                            lru_next = rd_idx;
                            lrank_next = e.rank;
                            ltag_next = e.tag;
                            lbytes_next = e.bytes;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next = rd_idx;
                    end
                    phase_next = 1'b0;
                    ptr_next = ptr_inc;
                    if (ptr_inc == CW'(salru_pkg::ENTRIES))
                    begin
                        ptr_next = '0;
                        state_next = (state_reg == S_SCAN) ? S_DECIDE : S_NEXT;
                        if (state_reg == S_EVSCAN)
                        begin
                            // an earlier eviction is not the last one: put it out now
                            if (pend_reg)
                            begin
                                rv_next = 1'b1;
                                o_ev_next = 1'b1;
                                o_id_next = pend_id_reg;
                            end
                            // evict the LRU entry found (table non-empty here)
                            pend_next = 1'b1;
                            pend_id_next = lru_ok_next ? ltag_next : ltag_reg;
                            used_next = used_reg - USED_W'(lru_ok_next ? lbytes_next
                                                                        : lbytes_reg);
                            op_next = OP_DROP;
                            tgt_next = lru_ok_next ? lru_next : lru_reg;
                            trank_next = lru_ok_next ? lrank_next : lrank_reg;
                            valid_next[lru_ok_next ? lru_next : lru_reg] = 1'b0;
                            state_next = S_RANK;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                hit_next = found_reg;
                insert_after_next = 1'b0;
                if (act_reg == salru_pkg::ACT_REMOVE)
                begin
                    if (found_reg)
                    begin
                        used_next = used_reg - USED_W'(fbytes_reg);
                        valid_next[fidx_reg] = 1'b0;
                        op_next = OP_DROP;
                        tgt_next = fidx_reg;
                        trank_next = frank_reg;
                        state_next = S_RANK;
                        insert_after_next = 1'b0;
                        // remove never evicts: go straight to final after ranks
                        st_next = salru_pkg::ST_OK;
                    end
                    else
                    begin
                        st_next = salru_pkg::ST_ABSENT;
                        state_next = S_FINAL;
                    end
                end
                else if (CAP_W'(sz_reg) > cap_reg)
                begin
                    st_next = salru_pkg::ST_TOO_BIG;
                    state_next = S_FINAL;
                end
                else if (found_reg)
                begin
                    used_next = used_reg - USED_W'(fbytes_reg) + USED_W'(sz_reg);
                    op_next = OP_MRU;
                    tgt_next = fidx_reg;
                    trank_next = frank_reg;
                    state_next = S_RANK;
                end
                else if (!free_ok_reg)
                begin
                    // table full: evict LRU then insert into its slot
                    pend_next = 1'b1;
                    pend_id_next = ltag_reg;
                    used_next = used_reg - USED_W'(lbytes_reg);
                    valid_next[lru_reg] = 1'b0;
                    op_next = OP_DROP;
                    tgt_next = lru_reg;
                    trank_next = lrank_reg;
                    free_next = lru_reg;
                    insert_after_next = 1'b1;
                    state_next = S_RANK;
                end
                else
                begin
                    used_next = used_reg + USED_W'(sz_reg);
                    op_next = OP_INS;
                    tgt_next = free_reg;
                    state_next = S_RANK;
                end
            end
            S_RANK:
            begin
                if (phase_reg == 1'b0)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (op_reg == OP_INS && rd_idx == tgt_reg)
                    begin
                        ram_wdata.tag = id_reg;
                        ram_wdata.bytes = sz_reg;
                        ram_wdata.rank = '0;
                    end
                    else if (op_reg == OP_MRU && rd_idx == tgt_reg)
                    begin
                        ram_wdata.bytes = sz_reg;
                        ram_wdata.rank = '0;
                    end
                    else if (!vv)
                    begin
                        ram_we = 1'b0;
                    end
                    else if (op_reg == OP_DROP && e.rank > trank_reg)
                    begin
                        ram_wdata.rank = e.rank - IW'(1);
                    end
                    else if ((op_reg == OP_MRU && e.rank < trank_reg) || op_reg == OP_INS)
                    begin
                        ram_wdata.rank = e.rank + IW'(1);
                    end
                    phase_next = 1'b0;
                    ptr_next = ptr_inc;
                    if (ptr_inc == CW'(salru_pkg::ENTRIES))
                    begin
                        ptr_next = '0;
                        if (op_reg == OP_INS)
                        begin
                            valid_next[tgt_reg] = 1'b1;
                        end
                        if (insert_after_reg)
                        begin
                            insert_after_next = 1'b0;
                            used_next = used_reg + USED_W'(sz_reg);
                            op_next = OP_INS;
                            tgt_next = free_reg;
                        end
                        else if (act_reg == salru_pkg::ACT_REMOVE)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            state_next = S_NEXT;
                        end
                    end
                end
            end
            S_NEXT:
            begin
                if (used_reg > USED_W'(cap_reg) && valid_reg != '0)
                begin
                    lru_ok_next = 1'b0;
                    phase_next = 1'b0;
                    ptr_next = '0;
                    state_next = S_EVSCAN;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                // final result, carrying the last eviction if one is pending
                rv_next = 1'b1;
                o_hit_next = hit_reg;
                o_ev_next = pend_reg;
                o_id_next = pend_reg ? pend_id_reg : 64'd0;
                o_st_next = st_reg;
                o_used_next = used_reg[39:0];
                o_last_next = 1'b1;
                pend_next = 1'b0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg <= '0;
            used_reg <= '0;
            valid_reg <= '0;
            rv_reg <= 1'b0;
            pend_reg <= 1'b0;
            ptr_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            valid_reg <= valid_next;
            rv_reg <= rv_next;
            pend_reg <= pend_next;
            ptr_reg <= ptr_next;
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            act_reg <= action;
            id_reg <= object_id;
            sz_reg <= object_bytes;
        end
        found_reg <= found_next;
        fidx_reg <= fidx_next;
        fbytes_reg <= fbytes_next;
        frank_reg <= frank_next;
        free_ok_reg <= free_ok_next;
        free_reg <= free_next;
        lru_ok_reg <= lru_ok_next;
        lru_reg <= lru_next;
        lrank_reg <= lrank_next;
        ltag_reg <= ltag_next;
        lbytes_reg <= lbytes_next;
        op_reg <= op_next;
        tgt_reg <= tgt_next;
        trank_reg <= trank_next;
        insert_after_reg <= insert_after_next;
        hit_reg <= hit_next;
        st_reg <= st_next;
        pend_id_reg <= pend_id_next;
        o_hit_reg <= o_hit_next;
        o_ev_reg <= o_ev_next;
        o_id_reg <= o_id_next;
        o_st_reg <= o_st_next;
        o_used_reg <= o_used_next;
        o_last_reg <= o_last_next;
    end
endmodule
`default_nettype wire
